// File: sv/skb_pkg.sv
// Shared types and constants for the stable key bucket sort block.
// Depends on nothing; the design files refer to it by scoped names and the bench imports it.
package skb_pkg;

	localparam int MaxRecords = 64;
	localparam int KeyCount   = 101;
	localparam int TagBits    = 32;

	localparam int KeyW      = 7;
	localparam int TagFieldW = 32;

	typedef struct packed {
		logic [KeyW-1:0]      sort_key;
		logic [TagFieldW-1:0] record_tag;
		logic                 last_item;
	} skb_item_t;

	typedef struct packed {
		logic [KeyW-1:0]      out_key;
		logic [TagFieldW-1:0] out_tag;
		logic                 last_result;
		logic                 overflowed;
	} skb_result_t;

	// Broadcast control for every cell of the chain.
	typedef struct packed {
		logic ins;
		logic drain;
	} skb_cell_ctrl_t;

endpackage

// File: sv/skb_cell.sv
// One cell of the sorted insertion chain: holds one record and its valid bit.
// Depends on skb_pkg.
module skb_cell #(
	parameter int SW = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  skb_pkg::skb_cell_ctrl_t      ctrl,
	input  logic [skb_pkg::KeyW-1:0]     new_key,
	input  logic [SW-1:0]                new_tag,
	input  logic                         prev_gt,
	input  logic                         left_valid,
	input  logic [skb_pkg::KeyW-1:0]     left_key,
	input  logic [SW-1:0]                left_tag,
	input  logic                         right_valid,
	input  logic [skb_pkg::KeyW-1:0]     right_key,
	input  logic [SW-1:0]                right_tag,
	output logic                         gt,
	output logic                         valid,
	output logic [skb_pkg::KeyW-1:0]     key,
	output logic [SW-1:0]                tag
);

	logic                     valid_q;
	logic [skb_pkg::KeyW-1:0] key_q;
	logic [SW-1:0]            tag_q;

	// Equal keys stay ahead of the newcomer, which keeps arrival order.
	assign gt    = !valid_q || (key_q > new_key);
	assign valid = valid_q;
	assign key   = key_q;
	assign tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.drain) begin
			valid_q <= right_valid;
		end else if (ctrl.ins && gt) begin
			valid_q <= prev_gt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (ctrl.ins && gt) begin
			key_q <= prev_gt ? left_key : new_key;
			tag_q <= prev_gt ? left_tag : new_tag;
		end
	end

endmodule

// File: sv/stable_key_bucket_sort.sv
// Top level of the stable key bucket sort: a sorted chain of record cells.
// Depends on skb_pkg and skb_cell.
//
// Channel   Direction  Handshake              Payload
// item      in         start & !busy          skb_pkg::skb_item_t
// result    out        strobe, one cycle      skb_pkg::skb_result_t
//
// For each accepted record beat the chain compares the new key against
// every cell at once and the record drops into place while larger ones
// shift one cell toward the tail. After the beat marked last, busy rises
// and the chain shifts toward the head one cell per cycle, one result per
// stored record. Reset clears all valid bits and the overflow mark; there
// is no clearing pass. The receiver cannot stall, so results leave at the
// drain rate without holding.
module stable_key_bucket_sort #(
	parameter int MAX_RECORDS = skb_pkg::MaxRecords,
	parameter int KEY_COUNT   = skb_pkg::KeyCount,
	parameter int TAG_BITS    = skb_pkg::TagBits
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  skb_pkg::skb_item_t   item,
	output logic                 strobe,
	output skb_pkg::skb_result_t result
);

	// Stored tag width: the field never carries more than its 32 bits.
	localparam int SW = (TAG_BITS < skb_pkg::TagFieldW) ? TAG_BITS : skb_pkg::TagFieldW;

	logic                     draining_q;
	logic                     overflow_q;
	logic                     accept;
	logic                     full;
	logic                     final_beat;
	logic [skb_pkg::KeyW-1:0] sat_key;
	logic [SW-1:0]            new_tag;
	skb_pkg::skb_cell_ctrl_t  ctrl;

	logic                     gt_w    [MAX_RECORDS];
	logic                     valid_w [MAX_RECORDS];
	logic [skb_pkg::KeyW-1:0] key_w   [MAX_RECORDS];
	logic [SW-1:0]            tag_w   [MAX_RECORDS];

	assign accept = start && !draining_q;
	assign busy   = draining_q;
	// Tail cell occupied means the chain is full; drop the record then.
	assign full   = valid_w[MAX_RECORDS-1];

	// Saturate keys above the top of the range.
	always_comb begin
		if (32'(item.sort_key) > KEY_COUNT - 1) begin
			sat_key = skb_pkg::KeyW'(KEY_COUNT - 1);
		end else begin
			sat_key = item.sort_key;
		end
	end

	assign new_tag = item.record_tag[SW-1:0];

	assign ctrl.ins   = accept && !full;
	assign ctrl.drain = draining_q;

	genvar g;
	generate
		for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
			logic                     pgt;
			logic                     lv;
			logic [skb_pkg::KeyW-1:0] lk;
			logic [SW-1:0]            lt;
			logic                     rv;
			logic [skb_pkg::KeyW-1:0] rk;
			logic [SW-1:0]            rt;

			// Head cell has no left neighbor; its prev_gt is low so it loads new data.
			if (g == 0) begin : g_head
				assign pgt = 1'b0;
				assign lv  = 1'b0;
				assign lk  = '0;
				assign lt  = '0;
			end else begin : g_body
				assign pgt = gt_w[g-1];
				assign lv  = valid_w[g-1];
				assign lk  = key_w[g-1];
				assign lt  = tag_w[g-1];
			end

			// Tail cell empties during the drain.
			if (g == MAX_RECORDS - 1) begin : g_tail
				assign rv = 1'b0;
				assign rk = '0;
				assign rt = '0;
			end else begin : g_inner
				assign rv = valid_w[g+1];
				assign rk = key_w[g+1];
				assign rt = tag_w[g+1];
			end

			skb_cell #(
				.SW(SW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.new_key    (sat_key),
				.new_tag    (new_tag),
				.prev_gt    (pgt),
				.left_valid (lv),
				.left_key   (lk),
				.left_tag   (lt),
				.right_valid(rv),
				.right_key  (rk),
				.right_tag  (rt),
				.gt         (gt_w[g]),
				.valid      (valid_w[g]),
				.key        (key_w[g]),
				.tag        (tag_w[g])
			);
		end
	endgenerate

	// Head cell is the next result; the set ends when the cell behind it is empty.
	assign final_beat = !valid_w[1];

	assign strobe             = draining_q && valid_w[0];
	assign result.out_key     = key_w[0];
	assign result.out_tag     = skb_pkg::TagFieldW'(tag_w[0]);
	assign result.last_result = final_beat;
	assign result.overflowed  = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (draining_q) begin
			// Drop the drain and the overflow mark after the final result.
			if (final_beat || !valid_w[0]) begin
				draining_q <= 1'b0;
				overflow_q <= 1'b0;
			end
		end else if (accept) begin
			if (full) begin
				overflow_q <= 1'b1;
			end
			if (item.last_item) begin
				draining_q <= 1'b1;
			end
		end
	end

endmodule

// File: sv/skb_checker.sv
// Port-level checks for the stable key bucket sort, bound to its top level.
// Depends on skb_pkg and stable_key_bucket_sort.
module skb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 busy,
	input logic                 strobe,
	input skb_pkg::skb_result_t result
);

	// Results appear only while the block is draining.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result beat outside a drain");

	// The final result of a set releases the block.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_result |=> !busy)
		else $error("busy held after final result");

	// A drain runs without gaps until its final result.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_result |=> strobe)
		else $error("gap inside a drain");

	// A drain opens with a result at once.
	a_drain_opens: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> strobe)
		else $error("drain began without a result");

	// The overflow flag holds across one set.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_result |=> result.overflowed == $past(result.overflowed))
		else $error("overflow flag changed within a set");

endmodule

bind stable_key_bucket_sort skb_checker u_skb_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.busy  (busy),
	.strobe(strobe),
	.result(result)
);

// File: tb/sv/tb_stable_key_bucket_sort.sv
`timescale 1ns / 100ps
// Self-checking bench for stable_key_bucket_sort: drives record sets and checks the sorted drain.
// Depends on skb_pkg and the stable_key_bucket_sort top level.
module tb_stable_key_bucket_sort;
	import skb_pkg::*;

	localparam int CycleLimit = 200_000;
	localparam int RandomItems = 180;

	// Predicts the drain order of each set and checks emitted results against it.
	class sort_scoreboard;
		logic [KeyW-1:0]      held_keys[$];
		logic [TagFieldW-1:0] held_tags[$];
		bit                   dropped;
		skb_result_t          drain_order[$];
		int                   errors;

		// Store one accepted beat; on the last beat, build the whole drain.
		function void take_record(skb_item_t it);
			logic [KeyW-1:0]      key;
			logic [TagFieldW-1:0] tag_mask;
			skb_result_t          res;
			int                   emitted;
			key = (it.sort_key > KeyCount - 1) ? KeyW'(KeyCount - 1) : it.sort_key;
			tag_mask = (TagBits >= TagFieldW) ? '1 : TagFieldW'((64'd1 << TagBits) - 1);
			if (held_keys.size() < MaxRecords) begin
				held_keys.push_back(key);
				held_tags.push_back(it.record_tag & tag_mask);
			end else begin
				dropped = 1'b1;
			end
			if (!it.last_item)
				return;
			emitted = 0;
			// Walk keys in ascending order; arrival order breaks ties.
			for (int k = 0; k < KeyCount; k++) begin
				for (int i = 0; i < held_keys.size(); i++) begin
					if (held_keys[i] == k) begin
						res.out_key     = held_keys[i];
						res.out_tag     = held_tags[i];
						res.last_result = 1'b0;
						res.overflowed  = dropped;
						drain_order.push_back(res);
						emitted++;
					end
				end
			end
			if (emitted > 0)
				drain_order[drain_order.size() - 1].last_result = 1'b1;
			held_keys.delete();
			held_tags.delete();
			dropped = 1'b0;
		endfunction

		function void check_emitted(skb_result_t got);
			skb_result_t want;
			if (drain_order.size() == 0) begin
				$display("%0t: unexpected result key=%0d tag=%h last=%b ovf=%b", $time,
					got.out_key, got.out_tag, got.last_result, got.overflowed);
				errors++;
				return;
			end
			want = drain_order.pop_front();
			if (got.out_key !== want.out_key) begin
				$display("%0t: out_key expected %0d actual %0d", $time, want.out_key, got.out_key);
				errors++;
			end
			if (got.out_tag !== want.out_tag) begin
				$display("%0t: out_tag expected %h actual %h", $time, want.out_tag, got.out_tag);
				errors++;
			end
			if (got.last_result !== want.last_result) begin
				$display("%0t: last_result expected %b actual %b", $time,
					want.last_result, got.last_result);
				errors++;
			end
			if (got.overflowed !== want.overflowed) begin
				$display("%0t: overflowed expected %b actual %b", $time,
					want.overflowed, got.overflowed);
				errors++;
			end
		endfunction

		function int pending();
			return drain_order.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	skb_item_t   item = '0;
	logic        strobe;
	skb_result_t result;

	sort_scoreboard sb;
	int             burst_left = 0;
	int             cycle_count = 0;

	stable_key_bucket_sort DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: end the run if the drain never completes.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				sb.pending());
			$display("FAIL stable_key_bucket_sort");
			$finish;
		end
	end

	// Results cannot be held off: take every strobed beat at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe === 1'b1)
				sb.check_emitted(result);
			else if (strobe !== 1'b0) begin
				$display("%0t: strobe expected 0 or 1 actual %b", $time, strobe);
				sb.errors++;
			end
		end
	end

	// Present one beat and hold it until the block takes it. The sender runs in
	// bursts: when a burst is used up, drop start for a random gap first. A gap
	// can land anywhere, including in the middle of a drain.
	task automatic send_record(skb_item_t it);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// Mostly short bursts, now and then a long stretch with no idling.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		sb.take_record(it);
	endtask

	initial begin
		int         sat_keys[7];
		int         bit_keys[7];
		int         sent;
		int         set_no;
		int         set_size;
		skb_item_t  it;

		sat_keys = '{127, 101, 5, 5, 0, 100, 5};
		bit_keys = '{64, 32, 16, 8, 4, 2, 1};
		sb = new();

		// Hold reset, then release it on an edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-record sets at both ends of the key and tag ranges.
		send_record('{sort_key: 7'd0, record_tag: 32'h0000_0000, last_item: 1'b1});
		send_record('{sort_key: 7'd100, record_tag: 32'hFFFF_FFFF, last_item: 1'b1});

		// Keys above the top saturate and then sort in arrival order with real 100s.
		foreach (sat_keys[i])
			send_record('{sort_key: KeyW'(sat_keys[i]), record_tag: 32'hA5A5_0000 + i,
				last_item: (i == 6)});

		// Equal keys must come out in arrival order.
		for (int i = 0; i < 4; i++)
			send_record('{sort_key: 7'd3, record_tag: 32'(i + 1), last_item: (i == 3)});

		// Descending single-bit keys reverse completely.
		foreach (bit_keys[i])
			send_record('{sort_key: KeyW'(bit_keys[i]), record_tag: $urandom,
				last_item: (i == 6)});

		// Random sets: mostly small, one that exactly fills the store, and one
		// that overruns it so the closing last beat itself is dropped.
		sent = 0;
		set_no = 0;
		while (sent < RandomItems) begin
			if (set_no == 2)
				set_size = MaxRecords;
			else if (set_no == 5)
				set_size = MaxRecords + $urandom_range(1, 6);
			else
				set_size = $urandom_range(1, 10);
			for (int i = 0; i < set_size; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: it.sort_key = KeyW'($urandom_range(0, KeyCount - 1));
					6, 7:             it.sort_key = KeyW'($urandom_range(0, 3));
					8:                it.sort_key = KeyW'($urandom_range(KeyCount, 127));
					default:          it.sort_key = $urandom_range(0, 1) ? KeyW'(KeyCount - 1) : '0;
				endcase
				it.record_tag = $urandom;
				it.last_item  = (i == set_size - 1);
				send_record(it);
			end
			sent += set_size;
			set_no++;
		end
		start <= 1'b0;

		// Wait out the last drain, then give stray beats a chance to show up.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (MaxRecords + 10) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS stable_key_bucket_sort");
		end else begin
			if (sb.pending() != 0)
				$display("%0d expected results never arrived", sb.pending());
			$display("FAIL stable_key_bucket_sort");
		end
		$finish;
	end

endmodule
